// File: rtl/ccr_pkg.sv
// Shared constants, codes and helper functions for the clipped circle rasterizer.
// Depends on nothing; every other file imports it.
`default_nettype none

package ccr_pkg;

    // Item kinds on the command channel.
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_LEFT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_RIGHT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_BOTTOM = 2'd2;

    // Pixel colour width.
    localparam int COLOR_BITS = 24;

    // Eight octant mirrors per walker position.
    localparam int NUM_MIRRORS = 8;
    localparam int MIRROR_BITS = 3;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Width of one packed job: plot and done flags, centre, walker offsets, colour.
    function automatic int job_bits(input int coord_bits);
        return 2 + 4 * coord_bits + COLOR_BITS;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ccr_if.sv
// Valid/ready channel interfaces for the command items and the pixel items.
// Depends on ccr_pkg for the colour width.
`default_nettype none

interface ccr_cmd_if
    import ccr_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [COORD_BITS-1:0]   center_x;
    logic [COORD_BITS-1:0]   center_y;
    logic [COORD_BITS-2:0]   radius;
    logic [COLOR_BITS-1:0]   color;

    modport source (output valid, kind, center_x, center_y, radius, color, input ready);
    modport sink   (input valid, kind, center_x, center_y, radius, color, output ready);
endinterface

interface ccr_pixel_if
    import ccr_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                    valid;
    logic                    ready;
    logic [COORD_BITS-1:0]   pixel_x;
    logic [COORD_BITS-1:0]   pixel_y;
    logic [COLOR_BITS-1:0]   pixel_color;
    logic                    pixel_valid;
    logic                    circle_done;
    logic                    last;

    modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_valid,
                    circle_done, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, pixel_valid,
                    circle_done, last, output ready);
endinterface

`default_nettype wire

// File: rtl/clipped_circle_rasterizer.sv
// Top level of the clipped midpoint circle rasterizer: clip registers and the front/back split.
// Depends on ccr_pkg, ccr_if, ccr_front, ccr_queue and ccr_back.
`default_nettype none

// A start item loads centre, radius and colour and answers with one empty result.
// Each advance item takes one midpoint step and yields one result per visible mirrored
// pixel (one to eight), or one empty result when nothing is visible; the last result of
// an item carries last, and every result of the finishing item carries circle_done.
// The front end accepts one item per cycle while its two-entry job queue has room; the
// back end sends one result per cycle while the pixel channel is ready, so the pixel
// stream, at one result per visible pixel of an advance item (at least one), sets the
// sustained item rate. Clip registers may only be written while the block is idle.
module clipped_circle_rasterizer
    import ccr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ccr_cmd_if.sink                          cmd,
    ccr_pixel_if.source                      pixel,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [COORD_BITS:0]         cfg_data
);

    localparam int JOB_W = job_bits(COORD_BITS);

    logic [COORD_BITS-1:0]   clip_left_reg;
    logic [COORD_BITS:0]     clip_right_reg;
    logic [COORD_BITS:0]     clip_bottom_reg;

    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_not_empty;
    logic [JOB_W-1:0]        q_in;
    logic [JOB_W-1:0]        q_head;

    // Clip window registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= '0;
            clip_right_reg  <= (COORD_BITS+1)'(1 << COORD_BITS);
            clip_bottom_reg <= (COORD_BITS+1)'(1 << COORD_BITS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLIP_LEFT:   clip_left_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_CLIP_RIGHT:  clip_right_reg  <= cfg_data;
                CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    ccr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    ccr_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    ccr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .clip_left   (clip_left_reg),
        .clip_right  (clip_right_reg),
        .clip_bottom (clip_bottom_reg),
        .pixel       (pixel)
    );

endmodule

`default_nettype wire

// File: rtl/ccr_front.sv
// Front end: accepts command items, runs the midpoint walker and issues one job per item.
// Depends on ccr_pkg and the command channel interface in ccr_if.
`default_nettype none

module ccr_front
    import ccr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    ccr_cmd_if.sink                                  cmd,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output logic [job_bits(COORD_BITS)-1:0]          q_data
);

    localparam int DW = COORD_BITS + 4;
    localparam int DEC_INIT    = 3;
    localparam int DEC_STEP_E  = 6;
    localparam int DEC_STEP_SE = 10;

    typedef struct packed {
        logic                    plot;
        logic                    done;
        logic [COORD_BITS-1:0]   cx;
        logic [COORD_BITS-1:0]   cy;
        logic [COORD_BITS-1:0]   a;
        logic [COORD_BITS-1:0]   b;
        logic [COLOR_BITS-1:0]   color;
    } job_t;

    logic [COORD_BITS-1:0]   centre_x_reg, centre_x_next;
    logic [COORD_BITS-1:0]   centre_y_reg, centre_y_next;
    logic [COORD_BITS-1:0]   walk_x_reg, walk_x_next;
    logic [COORD_BITS-1:0]   walk_y_reg, walk_y_next;
    logic signed [DW-1:0]    decision_reg, decision_next;
    logic [COLOR_BITS-1:0]   colour_reg, colour_next;
    logic                    drawing_reg, drawing_next;

    logic                    accept;
    logic signed [DW-1:0]    wx_ext;
    logic signed [DW-1:0]    wy_ext;
    logic signed [DW-1:0]    dec_start;
    logic signed [DW-1:0]    dec_east;
    logic signed [DW-1:0]    dec_south_east;
    job_t                    job;

    // An item is taken whenever the queue has room.
    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign q_push    = accept;
    assign q_data    = job;

    // Decision term arithmetic.
    assign wx_ext         = signed'(DW'(walk_x_reg));
    assign wy_ext         = signed'(DW'(walk_y_reg));
    assign dec_start      = DW'(DEC_INIT) - (DW'(cmd.radius) << 1);
    assign dec_east       = decision_reg + (wx_ext <<< 2) + DW'(DEC_STEP_E);
    assign dec_south_east = decision_reg + ((wx_ext - wy_ext) <<< 2) + DW'(DEC_STEP_SE);

    // Walker update and job build.
    always_comb
    begin
        centre_x_next = centre_x_reg;
        centre_y_next = centre_y_reg;
        walk_x_next   = walk_x_reg;
        walk_y_next   = walk_y_reg;
        decision_next = decision_reg;
        colour_next   = colour_reg;
        drawing_next  = drawing_reg;

        job.plot  = 1'b0;
        job.done  = 1'b0;
        job.cx    = centre_x_reg;
        job.cy    = centre_y_reg;
        job.a     = walk_x_reg;
        job.b     = walk_y_reg;
        job.color = colour_reg;

        if (cmd.kind == KIND_START)
        begin
            centre_x_next = cmd.center_x;
            centre_y_next = cmd.center_y;
            colour_next   = cmd.color;
            walk_x_next   = '0;
            walk_y_next   = COORD_BITS'(cmd.radius);
            decision_next = dec_start;
            drawing_next  = 1'b1;
        end
        else if (drawing_reg)
        begin
            if (walk_x_reg < walk_y_reg)
            begin
                job.plot = 1'b1;
                if (decision_reg[DW-1])
                begin
                    decision_next = dec_east;
                end
                else
                begin
                    decision_next = dec_south_east;
                    walk_y_next   = walk_y_reg - COORD_BITS'(1);
                end
                walk_x_next = walk_x_reg + COORD_BITS'(1);
            end
            else
            begin
                // Walker has reached the diagonal: plot it if exact, then finish.
                job.plot     = (walk_x_reg == walk_y_reg);
                job.done     = 1'b1;
                drawing_next = 1'b0;
            end
        end
    end

    // Walker state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            walk_x_reg   <= '0;
            walk_y_reg   <= '0;
            decision_reg <= '0;
            colour_reg   <= '0;
            drawing_reg  <= 1'b0;
        end
        else if (accept)
        begin
            centre_x_reg <= centre_x_next;
            centre_y_reg <= centre_y_next;
            walk_x_reg   <= walk_x_next;
            walk_y_reg   <= walk_y_next;
            decision_reg <= decision_next;
            colour_reg   <= colour_next;
            drawing_reg  <= drawing_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ccr_queue.sv
// Small register queue that decouples the front end from the pixel back end.
// Depends on ccr_pkg only through the shared import convention.
`default_nettype none

module ccr_queue
    import ccr_pkg::*;
#(
    parameter int WIDTH = 74,
    parameter int DEPTH = 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic                    full,
    output logic                    not_empty,
    output logic [WIDTH-1:0]        head_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]      entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The occupancy never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("queue occupancy above depth");

    // A full queue with no pop keeps its count.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> full)
        else $error("full queue lost an entry without a pop");

endmodule

`default_nettype wire

// File: rtl/ccr_back.sv
// Back end: mirrors each job into up to eight pixels, clips them, sends one per unstalled cycle.
// Depends on ccr_pkg and the pixel channel interface in ccr_if.
`default_nettype none

module ccr_back
    import ccr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_not_empty,
    input  wire logic [job_bits(COORD_BITS)-1:0]     q_data,
    output logic                                     q_pop,
    input  wire logic [COORD_BITS-1:0]               clip_left,
    input  wire logic [COORD_BITS:0]                 clip_right,
    input  wire logic [COORD_BITS:0]                 clip_bottom,
    ccr_pixel_if.source                              pixel
);

    localparam int W = COORD_BITS + 2;

    typedef struct packed {
        logic                    plot;
        logic                    done;
        logic [COORD_BITS-1:0]   cx;
        logic [COORD_BITS-1:0]   cy;
        logic [COORD_BITS-1:0]   a;
        logic [COORD_BITS-1:0]   b;
        logic [COLOR_BITS-1:0]   color;
    } job_t;

    job_t                    job_reg;
    logic                    job_valid_reg;
    logic [NUM_MIRRORS-1:0]  sent_reg;

    logic                    out_valid_reg;
    logic [COORD_BITS-1:0]   out_x_reg;
    logic [COORD_BITS-1:0]   out_y_reg;
    logic [COLOR_BITS-1:0]   out_color_reg;
    logic                    out_pv_reg;
    logic                    out_done_reg;
    logic                    out_last_reg;

    logic signed [W-1:0]     cx_s, cy_s, a_s, b_s;
    logic signed [W-1:0]     px [NUM_MIRRORS];
    logic signed [W-1:0]     py [NUM_MIRRORS];
    logic [NUM_MIRRORS-1:0]  mirror_en;
    logic [NUM_MIRRORS-1:0]  vis;
    logic [NUM_MIRRORS-1:0]  pend;
    logic [NUM_MIRRORS-1:0]  sel_onehot;
    logic [MIRROR_BITS-1:0]  sel;
    logic [COORD_BITS:0]     right_cap;
    logic [COORD_BITS:0]     bottom_cap;
    logic signed [W-1:0]     left_s, right_s, bottom_s;
    logic                    a_nz, b_nz, off_diag;
    logic                    is_last;
    logic                    issue;
    logic                    take;

    // Mirror coordinates of the current walker offsets.
    assign cx_s = signed'(W'(job_reg.cx));
    assign cy_s = signed'(W'(job_reg.cy));
    assign a_s  = signed'(W'(job_reg.a));
    assign b_s  = signed'(W'(job_reg.b));

    always_comb
    begin
        px[0] = cx_s + a_s;  py[0] = cy_s + b_s;
        px[1] = cx_s - a_s;  py[1] = cy_s + b_s;
        px[2] = cx_s + a_s;  py[2] = cy_s - b_s;
        px[3] = cx_s - a_s;  py[3] = cy_s - b_s;
        px[4] = cx_s + b_s;  py[4] = cy_s + a_s;
        px[5] = cx_s + b_s;  py[5] = cy_s - a_s;
        px[6] = cx_s - b_s;  py[6] = cy_s + a_s;
        px[7] = cx_s - b_s;  py[7] = cy_s - a_s;
    end

    // Skip mirrors that would repeat a pixel: zero offsets and the swapped set on the diagonal.
    assign a_nz     = |job_reg.a;
    assign b_nz     = |job_reg.b;
    assign off_diag = (job_reg.a != job_reg.b);
    assign mirror_en = {off_diag && a_nz && b_nz, off_diag && b_nz, off_diag && a_nz, off_diag,
                        a_nz && b_nz, b_nz, a_nz, 1'b1};

    // Clip window; the right and bottom bounds are capped at the coordinate range.
    assign right_cap  = (clip_right  > (COORD_BITS+1)'(1 << COORD_BITS))
                        ? (COORD_BITS+1)'(1 << COORD_BITS) : clip_right;
    assign bottom_cap = (clip_bottom > (COORD_BITS+1)'(1 << COORD_BITS))
                        ? (COORD_BITS+1)'(1 << COORD_BITS) : clip_bottom;
    assign left_s   = signed'(W'(clip_left));
    assign right_s  = signed'(W'(right_cap));
    assign bottom_s = signed'(W'(bottom_cap));

    always_comb
    begin
        for (int i = 0; i < NUM_MIRRORS; i++)
        begin
            vis[i] = mirror_en[i] && (px[i] >= left_s) && (px[i] < right_s)
                     && (py[i] >= signed'(W'(0))) && (py[i] < bottom_s);
        end
    end

    // Lowest pending mirror goes next.
    assign pend = job_reg.plot ? (vis & ~sent_reg) : '0;

    always_comb
    begin
        sel = '0;
        for (int i = NUM_MIRRORS - 1; i >= 0; i--)
        begin
            if (pend[i])
            begin
                sel = MIRROR_BITS'(i);
            end
        end
    end

    assign sel_onehot = NUM_MIRRORS'(1) << sel;
    assign is_last    = ((pend & ~sel_onehot) == '0);

    // Handshake between the job register, the output register and the queue.
    assign issue = job_valid_reg && (!out_valid_reg || pixel.ready);
    assign take  = !job_valid_reg || (issue && is_last);
    assign q_pop = take && q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                job_valid_reg <= q_not_empty;
                sent_reg      <= '0;
            end
            else if (issue)
            begin
                sent_reg <= sent_reg | sel_onehot;
            end

            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Job and result payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job_t'(q_data);
        end
        if (issue)
        begin
            out_done_reg <= job_reg.done;
            out_last_reg <= is_last;
            if (pend != '0)
            begin
                out_x_reg     <= px[sel][COORD_BITS-1:0];
                out_y_reg     <= py[sel][COORD_BITS-1:0];
                out_color_reg <= job_reg.color;
                out_pv_reg    <= 1'b1;
            end
            else
            begin
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_color_reg <= '0;
                out_pv_reg    <= 1'b0;
            end
        end
    end

    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_x     = out_x_reg;
    assign pixel.pixel_y     = out_y_reg;
    assign pixel.pixel_color = out_color_reg;
    assign pixel.pixel_valid = out_pv_reg;
    assign pixel.circle_done = out_done_reg;
    assign pixel.last        = out_last_reg;

    // A job that still has pixels to send stays in place.
    a_job_kept: assert property (@(posedge clk) disable iff (!rst_n)
        issue && !is_last |=> job_valid_reg)
        else $error("job dropped before its last pixel");

    // Only visible mirrors are ever marked as sent.
    a_sent_visible: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> ((sent_reg & ~vis) == '0))
        else $error("sent mask holds a mirror that is not visible");

    // An empty acknowledgement is always the only and final result of its item.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_pv_reg |-> out_last_reg)
        else $error("empty result not marked last");

endmodule

`default_nettype wire

// File: verif/clipped_circle_rasterizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for clipped_circle_rasterizer: directed table, then random circles.
// Depends on ccr_pkg and the ccr_cmd_if / ccr_pixel_if interfaces from the RTL.

module clipped_circle_rasterizer_tb;
    import ccr_pkg::*;

    localparam int CB = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEMS_PER_PHASE = 38;
    localparam int NUM_PHASES = 8;
    localparam int NUM_DIRECTED = 24;

    // How the result of a directed item is checked.
    typedef enum logic [1:0] {CHK_MODEL, CHK_ACK, CHK_ACK_DONE, CHK_CENTER_DONE} check_t;

    typedef struct packed {
        logic [CB-1:0]         x;
        logic [CB-1:0]         y;
        logic [COLOR_BITS-1:0] color;
        logic                  valid;
        logic                  done;
        logic                  last;
    } pixel_t;

    typedef struct packed {
        logic                  kind;
        logic [CB-1:0]         cx;
        logic [CB-1:0]         cy;
        logic [CB-2:0]         radius;
        logic [COLOR_BITS-1:0] color;
        check_t                chk;
    } cmd_row_t;

    // Directed items: idle advances, zero and full radius, a start while drawing, a radius
    // that passes the diagonal with nothing to plot, one that ends on it, and edge centers.
    localparam cmd_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_ACK},
        '{KIND_START,   12'h000, 12'h000, 11'h000, 24'hFFFFFF, CHK_ACK},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'hFFFFFF, CHK_CENTER_DONE},
        '{KIND_ADVANCE, 12'hFFF, 12'hFFF, 11'h7FF, 24'h000000, CHK_ACK},
        '{KIND_START,   12'hFFF, 12'hFFF, 11'h7FF, 24'h000000, CHK_ACK},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_ADVANCE, 12'hFFF, 12'hFFF, 11'h7FF, 24'hFFFFFF, CHK_MODEL},
        '{KIND_START,   12'h800, 12'h800, 11'h001, 24'hA5A5A5, CHK_ACK},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_ACK_DONE},
        '{KIND_START,   12'h064, 12'h064, 11'h003, 24'h5A5A5A, CHK_ACK},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_ACK},
        '{KIND_START,   12'h005, 12'h003, 11'h7FF, 24'h0F0F0F, CHK_ACK},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_START,   12'hABC, 12'h543, 11'h2AA, 24'h123456, CHK_ACK},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_START,   12'h543, 12'hABC, 11'h555, 24'hEDCBA9, CHK_ACK},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL},
        '{KIND_ADVANCE, 12'h000, 12'h000, 11'h000, 24'h000000, CHK_MODEL}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CB:0]               cfg_data;

    ccr_cmd_if   #(.COORD_BITS(CB)) cmd_ch ();
    ccr_pixel_if #(.COORD_BITS(CB)) pix_ch ();

    clipped_circle_rasterizer #(.COORD_BITS(CB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .pixel     (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Checking style of the item on the command channel, driven along with it.
    check_t item_check;

    // Results still owed by the block; updated at the clock edge.
    int pending = 0;

    bit tail_quiet;
    int sink_stall_pct;
    int sink_hold = 0;
    int stuck_cycles = 0;

    int mismatches = 0;
    int items_sent = 0;
    int pixels_seen = 0;
    int circles_closed = 0;

    // Window the driver aims circle centers at.
    int drv_left = 0;
    int drv_bottom = 4096;

    pixel_t expected_pixels[$];
    pixel_t step_pixels[$];

    // Circle tracer state and its copy of the clip window.
    logic [CB-1:0]         win_left = '0;
    logic [CB:0]           win_right = 13'd4096;
    logic [CB:0]           win_bottom = 13'd4096;
    logic [CB-1:0]         ctr_x = '0;
    logic [CB-1:0]         ctr_y = '0;
    logic [CB-1:0]         off_a = '0;
    logic [CB-1:0]         off_b = '0;
    int                    midpoint_err = 0;
    logic [COLOR_BITS-1:0] ink = '0;
    bit                    tracing = 1'b0;
    bit                    closing = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_failure(input string what, input pixel_t want, input pixel_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s: expected x=%0d y=%0d color=%06h valid=%0b done=%0b last=%0b",
                     what, want.x, want.y, want.color, want.valid, want.done, want.last);
            $display("    got      x=%0d y=%0d color=%06h valid=%0b done=%0b last=%0b",
                     got.x, got.y, got.color, got.valid, got.done, got.last);
        end
    endtask

    // Keep one mirrored pixel if it falls inside the window, capped at the coordinate range.
    task automatic keep_pixel(input int px, input int py);
        int right_lim;
        int bottom_lim;
        pixel_t p;
        right_lim = (int'(win_right) > (1 << CB)) ? (1 << CB) : int'(win_right);
        bottom_lim = (int'(win_bottom) > (1 << CB)) ? (1 << CB) : int'(win_bottom);
        if (px >= int'(win_left) && px < right_lim && py >= 0 && py < bottom_lim)
        begin
            p.x = px[CB-1:0];
            p.y = py[CB-1:0];
            p.color = ink;
            p.valid = 1'b1;
            p.done = closing;
            p.last = 1'b0;
            step_pixels.push_back(p);
        end
    endtask

    // The eight octant mirrors, skipping the ones that would repeat a pixel.
    task automatic plot_mirrors();
        int x;
        int y;
        int a;
        int b;
        x = int'(ctr_x);
        y = int'(ctr_y);
        a = int'(off_a);
        b = int'(off_b);
        keep_pixel(x + a, y + b);
        if (a != 0) keep_pixel(x - a, y + b);
        if (b != 0) keep_pixel(x + a, y - b);
        if (a != 0 && b != 0) keep_pixel(x - a, y - b);
        if (a != b)
        begin
            keep_pixel(x + b, y + a);
            if (a != 0) keep_pixel(x + b, y - a);
            if (b != 0) keep_pixel(x - b, y + a);
            if (a != 0 && b != 0) keep_pixel(x - b, y - a);
        end
    endtask

    // One midpoint step of the tracer; leaves the results of the item in step_pixels.
    task automatic trace_step(input logic kind, input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                              input logic [CB-2:0] r, input logic [COLOR_BITS-1:0] col);
        pixel_t tail;
        step_pixels.delete();
        closing = 1'b0;
        if (kind == KIND_START)
        begin
            ctr_x = cx;
            ctr_y = cy;
            ink = col;
            off_a = '0;
            off_b = {1'b0, r};
            midpoint_err = 3 - 2 * int'(r);
            tracing = 1'b1;
        end
        else if (tracing)
        begin
            if (off_a < off_b)
            begin
                plot_mirrors();
                if (midpoint_err < 0)
                    midpoint_err = midpoint_err + 4 * int'(off_a) + 6;
                else
                begin
                    midpoint_err = midpoint_err + 4 * (int'(off_a) - int'(off_b)) + 10;
                    off_b = off_b - CB'(1);
                end
                off_a = off_a + CB'(1);
            end
            else
            begin
                closing = 1'b1;
                if (off_a == off_b)
                    plot_mirrors();
                tracing = 1'b0;
            end
        end
        // Nothing visible: a single empty result stands for the item.
        if (step_pixels.size() == 0)
        begin
            tail = '0;
            tail.done = closing;
        end
        else
            tail = step_pixels.pop_back();
        tail.last = 1'b1;
        step_pixels.push_back(tail);
    endtask

    // Track config writes and accepted items, and check every result in order.
    always @(posedge clk)
    begin : watch
        pixel_t got;
        pixel_t want;
        int pushed;
        int popped;
        pushed = 0;
        popped = 0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLIP_LEFT:   win_left = cfg_data[CB-1:0];
                    CFG_CLIP_RIGHT:  win_right = cfg_data;
                    CFG_CLIP_BOTTOM: win_bottom = cfg_data;
                    default: ;
                endcase
            end

            if (cmd_ch.valid && cmd_ch.ready)
            begin
                trace_step(cmd_ch.kind, cmd_ch.center_x, cmd_ch.center_y, cmd_ch.radius,
                           cmd_ch.color);
                // Directed rows with an obvious answer are checked against it instead.
                if (item_check != CHK_MODEL)
                begin
                    want = '0;
                    want.last = 1'b1;
                    if (item_check != CHK_ACK)
                        want.done = 1'b1;
                    if (item_check == CHK_CENTER_DONE)
                    begin
                        want.x = cmd_ch.center_x;
                        want.y = cmd_ch.center_y;
                        want.color = cmd_ch.color;
                        want.valid = 1'b1;
                    end
                    step_pixels.delete();
                    step_pixels.push_back(want);
                end
                pushed = step_pixels.size();
                foreach (step_pixels[k])
                    expected_pixels.push_back(step_pixels[k]);
            end

            if (pix_ch.valid && pix_ch.ready)
            begin
                got.x = pix_ch.pixel_x;
                got.y = pix_ch.pixel_y;
                got.color = pix_ch.pixel_color;
                got.valid = pix_ch.pixel_valid;
                got.done = pix_ch.circle_done;
                got.last = pix_ch.last;
                pixels_seen++;
                if (got.done && got.last)
                    circles_closed++;
                if (expected_pixels.size() == 0)
                    report_failure("Unexpected result", '0, got);
                else
                begin
                    popped = 1;
                    want = expected_pixels.pop_front();
                    if (got !== want)
                        report_failure("Result mismatch", want, got);
                end
            end
            pending <= pending + pushed - popped;
        end
    end

    // Result side: ready drops in bursts of random length.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_hold = 0;
            pix_ch.ready <= 1'b0;
        end
        else if (sink_hold > 0)
        begin
            sink_hold = sink_hold - 1;
            pix_ch.ready <= 1'b0;
        end
        else if (!tail_quiet && $urandom_range(0, 99) < sink_stall_pct)
        begin
            sink_hold = $urandom_range(0, 8);
            pix_ch.ready <= 1'b0;
        end
        else
            pix_ch.ready <= 1'b1;
    end

    // End the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one item and hold it until the block takes it.
    task automatic send_item(input logic kind, input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                             input logic [CB-2:0] r, input logic [COLOR_BITS-1:0] col,
                             input check_t chk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= kind;
        cmd_ch.center_x <= cx;
        cmd_ch.center_y <= cy;
        cmd_ch.radius <= r;
        cmd_ch.color <= col;
        item_check <= chk;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        items_sent++;
    endtask

    // Stop sending until every owed result has come back.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Gap after an item: now and then a full drain, otherwise a random burst.
    task automatic pace(input int gap_pct);
        int n;
        if (gap_pct != 0 && $urandom_range(0, 99) < 2)
            drain();
        else if ($urandom_range(0, 99) < gap_pct)
        begin
            n = $urandom_range(1, 9);
            cmd_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic program_window(input logic [CB:0] l, input logic [CB:0] r,
                                  input logic [CB:0] b);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CLIP_LEFT;
        cfg_data <= l;
        @(posedge clk);
        cfg_index <= CFG_CLIP_RIGHT;
        cfg_data <= r;
        @(posedge clk);
        cfg_index <= CFG_CLIP_BOTTOM;
        cfg_data <= b;
        @(posedge clk);
        cfg_we <= 1'b0;
        drv_left = int'(l[CB-1:0]);
        drv_bottom = (b > 13'd4096) ? 4096 : int'(b);
    endtask

    // One circle: mostly small and walked to the end, sometimes large and abandoned.
    task automatic draw_circle(input int gap_pct);
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB-2:0] r;
        int pick;
        int n_adv;
        int wx;
        int wy;
        int d;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            r = (CB-1)'($urandom);
            n_adv = $urandom_range(0, 6);
        end
        else
        begin
            if (pick < 75)
                r = (CB-1)'($urandom_range(0, 20));
            else if (pick < 96)
                r = (CB-1)'($urandom_range(21, 90));
            else
                r = (CB-1)'($urandom_range(91, 160));
            // Count the advances up to and including the finishing one.
            wx = 0;
            wy = int'(r);
            d = 3 - 2 * int'(r);
            n_adv = 1;
            while (wx < wy)
            begin
                if (d < 0)
                    d = d + 4 * wx + 6;
                else
                begin
                    d = d + 4 * (wx - wy) + 10;
                    wy = wy - 1;
                end
                wx = wx + 1;
                n_adv = n_adv + 1;
            end
            if ($urandom_range(0, 9) == 0)
                n_adv = n_adv + 1;
        end

        // Half of the centers sit near the window's left and top or bottom edges.
        if ($urandom_range(0, 1) == 1)
        begin
            cx = CB'($urandom);
            cy = CB'($urandom);
        end
        else
        begin
            cx = CB'(drv_left + int'($urandom_range(0, 64)) - 32);
            cy = CB'(($urandom_range(0, 1) == 1 ? drv_bottom : 0)
                     + int'($urandom_range(0, 64)) - 32);
        end

        send_item(KIND_START, cx, cy, r, COLOR_BITS'($urandom), CHK_MODEL);
        pace(gap_pct);
        repeat (n_adv)
        begin
            send_item(KIND_ADVANCE, CB'($urandom), CB'($urandom), (CB-1)'($urandom),
                      COLOR_BITS'($urandom), CHK_MODEL);
            pace(gap_pct);
        end
    endtask

    initial
    begin : stimulus
        int phase_end;
        int gap_pct;
        logic [CB:0] l;
        logic [CB:0] r;
        logic [CB:0] b;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_CLIP_LEFT;
        cfg_data <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.kind <= KIND_START;
        cmd_ch.center_x <= '0;
        cmd_ch.center_y <= '0;
        cmd_ch.radius <= '0;
        cmd_ch.color <= '0;
        item_check <= CHK_MODEL;
        tail_quiet <= 1'b0;
        sink_stall_pct <= 20;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, run with the clip window as reset left it.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].cx, DIRECTED_ROWS[i].cy,
                      DIRECTED_ROWS[i].radius, DIRECTED_ROWS[i].color, DIRECTED_ROWS[i].chk);
            pace(20);
        end

        // Random circles under a series of clip windows, written only while idle.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (phase)
                0: begin l = 0;    r = 4096; b = 4096; end
                1: begin l = 100;  r = 400;  b = 300;  end
                2: begin l = 4095; r = 4096; b = 1;    end
                3: begin l = 0;    r = 8191; b = 8191; end
                4: begin l = 3000; r = 1000; b = 0;    end
                6: begin l = 1024; r = 3072; b = 2048; end
                default:
                begin
                    l = (CB+1)'($urandom);
                    r = (CB+1)'($urandom);
                    b = (CB+1)'($urandom);
                end
            endcase
            program_window(l, r, b);

            if (phase == NUM_PHASES - 1)
            begin
                gap_pct = 0;
                tail_quiet <= 1'b1;
                sink_stall_pct <= 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_stall_pct <= 0;
                    1: sink_stall_pct <= 10;
                    default: sink_stall_pct <= 35;
                endcase
            end

            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
            begin
                // Stray items with random contents between whole circles.
                if ($urandom_range(0, 99) < 8)
                begin
                    send_item(1'($urandom), CB'($urandom), CB'($urandom), (CB-1)'($urandom),
                              COLOR_BITS'($urandom), CHK_MODEL);
                    pace(gap_pct);
                end
                else
                    draw_circle(gap_pct);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (expected_pixels.size() != 0)
            report_failure("Missing result", expected_pixels.pop_front(), '0);

        $display("Covered %0d command items, %0d results and %0d closed circles,",
                 items_sent, pixels_seen, circles_closed);
        $display("under full, narrow, one-pixel, oversized, empty and random clip windows.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
